@@ hdl/sorted_sparse_vector_store_assert.svh @@
// Assertion macros shared by the sorted sparse vector store RTL.
// Needs signals clk and arst_n in the including module.
`ifndef SORTED_SPARSE_VECTOR_STORE_ASSERT_SVH
`define SORTED_SPARSE_VECTOR_STORE_ASSERT_SVH

// Property that must hold at every edge out of reset.
`define SSVS_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define SSVS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ssvs_pkg.sv @@
// Package for the sorted sparse vector store: sizes, opcodes, status codes.
// No dependencies.
package ssvs_pkg;
	localparam int CAPACITY = 256;
	localparam int KEY_BITS = 16;
	localparam int VAL_W    = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ENT_W    = KEY_BITS + VAL_W;

	localparam logic [1:0] OP_GET   = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_ABSENT   = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;
endpackage

@@ hdl/ssvs_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read a cycle.
// No dependencies.
module ssvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/sorted_sparse_vector_store.sv @@
// Sorted sparse vector store: key/value pairs in one RAM, binary search, shift insert.
// Depends on ssvs_pkg, ssvs_ram and sorted_sparse_vector_store_assert.svh.
//
//  word      valid      stall      fields
//  request   req_valid  req_stall  opcode, key, value_in
//  response  rsp_valid  rsp_stall  value_out, status, entry_count
//
// Get or set of a present key: p probes (at most log2(count)+1), then decide, finish.
// New key inserted: entries above the insert point move up, then the key is written.
// Clear and unused opcode go to finish. The RAM read port sets the probe rate.
// Reset zeroes the count and rsp_valid and idles the controller; the RAM is not cleared.
// A finished word waits in the response register while the next request is taken.
`include "sorted_sparse_vector_store_assert.svh"
module sorted_sparse_vector_store
	import ssvs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          opcode,
	input  logic [KEY_BITS-1:0] key,
	input  logic [VAL_W-1:0]    value_in,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [VAL_W-1:0]    value_out,
	output logic [1:0]          status,
	output logic [CNT_W-1:0]    entry_count
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_INS   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    used_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VAL_W-1:0]    val_q;
	logic [CNT_W-1:0]    lo_q, n_q, mid_q, pos_q, sh_q;
	logic                found_q;
	logic [VAL_W-1:0]    fval_q;
	logic [VAL_W-1:0]    res_val_q;
	logic [1:0]          res_st_q;
	logic                rsp_valid_q;
	logic [VAL_W-1:0]    value_out_q;
	logic [1:0]          status_q;
	logic [CNT_W-1:0]    entry_count_q;

	logic                we;
	logic [IDX_W-1:0]    waddr, raddr;
	logic [ENT_W-1:0]    wdata, rdata;
	logic [KEY_BITS-1:0] rkey;
	logic [VAL_W-1:0]    rval;
	logic                accept, hit, gt, out_free;
	logic [CNT_W-1:0]    lo_nx, n_nx, mid_nx, half, sh_nx, rd_dec, rd_sh;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rkey      = rdata[ENT_W-1:VAL_W];
	assign rval      = rdata[VAL_W-1:0];
	assign hit       = (key_q == rkey);
	assign gt        = (key_q > rkey);

	always_comb begin
		if (gt) begin
			lo_nx = mid_q + CNT_W'(1);
			n_nx  = (n_q - CNT_W'(1)) >> 1;
		end else begin
			lo_nx = lo_q;
			n_nx  = n_q >> 1;
		end
		mid_nx = lo_nx + (n_nx >> 1);
		half   = used_q >> 1;
		sh_nx  = sh_q - CNT_W'(1);
		rd_dec = used_q - CNT_W'(1);
		rd_sh  = sh_q - CNT_W'(2);
	end

	always_comb begin
		we    = 1'b0;
		waddr = pos_q[IDX_W-1:0];
		wdata = {key_q, val_q};
		raddr = half[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: raddr = half[IDX_W-1:0];
			S_SRCH: raddr = mid_nx[IDX_W-1:0];
			S_DEC: begin
				raddr = rd_dec[IDX_W-1:0];
				we    = (op_q == OP_SET) && found_q;
			end
			S_SHIFT: begin
				raddr = rd_sh[IDX_W-1:0];
				we    = 1'b1;
				waddr = sh_q[IDX_W-1:0];
				wdata = rdata;
			end
			S_INS: we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	ssvs_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((opcode == OP_GET) || (opcode == OP_SET)) begin
							state_q <= (used_q != '0) ? S_SRCH : S_DEC;
						end else begin
							if (opcode == OP_CLEAR) begin
								used_q <= '0;
							end
							state_q <= S_FIN;
						end
					end
				end
				S_SRCH: begin
					if (hit || (n_nx == '0)) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if ((op_q == OP_SET) && !found_q && (used_q != CNT_W'(CAPACITY))) begin
						state_q <= (used_q > pos_q) ? S_SHIFT : S_INS;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SHIFT: begin
					if (sh_nx <= pos_q) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					used_q  <= used_q + CNT_W'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= opcode;
					key_q     <= key;
					val_q     <= value_in;
					lo_q      <= '0;
					n_q       <= used_q;
					mid_q     <= half;
					found_q   <= 1'b0;
					pos_q     <= '0;
					res_val_q <= '0;
					res_st_q  <= ST_FOUND;
				end
			end
			S_SRCH: begin
				lo_q  <= lo_nx;
				n_q   <= n_nx;
				mid_q <= mid_nx;
				if (hit) begin
					found_q <= 1'b1;
					pos_q   <= mid_q;
					fval_q  <= rval;
				end else begin
					pos_q <= lo_nx;
				end
			end
			S_DEC: begin
				sh_q <= used_q;
				if (op_q == OP_GET) begin
					res_val_q <= found_q ? fval_q : '0;
					res_st_q  <= found_q ? ST_FOUND : ST_ABSENT;
				end else if (!found_q && (used_q == CNT_W'(CAPACITY))) begin
					res_st_q <= ST_FULL;
				end
			end
			S_SHIFT: sh_q <= sh_nx;
			S_INS: res_st_q <= ST_INSERTED;
			S_FIN: begin
				if (out_free) begin
					value_out_q   <= res_val_q;
					status_q      <= res_st_q;
					entry_count_q <= used_q;
				end
			end
			default: sh_q <= sh_q;
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign value_out   = value_out_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	`SSVS_CHECK(a_count_in_range, used_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`SSVS_CHECK(a_search_live, (state_q != S_SRCH) || (n_q != '0), "probe with empty window")
	`SSVS_CHECK(a_shift_above, (state_q != S_SHIFT) || (sh_q > pos_q), "shift below insert point")
	`SSVS_CHECK_NEXT(a_insert_count, state_q == S_INS, used_q == $past(used_q) + CNT_W'(1), "insert did not bump count")
endmodule
